/* hdl/mpa_pkg.sv */
`default_nettype none

package mpa_pkg;

  // Field and register widths.
  localparam int COORD_BITS    = 13;
  localparam int ACC_BITS      = 24;
  localparam int SCREEN_BITS   = 14;
  localparam int GAIN_BITS     = 13;
  localparam int SPD_LO_BITS   = 7;
  localparam int SPD_HI_BITS   = 9;
  localparam int OP_BITS       = 2;
  localparam int CODE_BITS     = 10;
  localparam int VAL_BITS      = 16;
  localparam int BTN_BITS      = 5;
  localparam int HELD_BITS     = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Arithmetic widths. The gain is unsigned Q10.16.
  localparam int FRAC_BITS   = 16;
  localparam int GPROD_BITS  = 2 * GAIN_BITS;
  localparam int MUL_BITS    = (ACC_BITS > GPROD_BITS) ? ACC_BITS : GPROD_BITS;
  localparam int PROD_BITS   = 2 * MUL_BITS;
  localparam int SQ_BITS     = 2 * ACC_BITS;
  localparam int QBITS       = PROD_BITS - FRAC_BITS;
  localparam int QSUM_BITS   = QBITS + 1;
  localparam int CENTRE_BITS = ((SCREEN_BITS > COORD_BITS) ? SCREEN_BITS : COORD_BITS) + 1;

  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [SCREEN_BITS-1:0]        screen_t;
  typedef logic [CODE_BITS-1:0]          code_t;
  typedef logic signed [VAL_BITS-1:0]    val_t;

  localparam coord_t COORD_MAX = '1;

  // Operation codes.
  typedef enum logic [OP_BITS-1:0] {
    OP_AXIS   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_BATCH  = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GAIN_NORMAL   = 3'd0,
    CFG_GAIN_BOOST    = 3'd1,
    CFG_SPEED_LOW     = 3'd2,
    CFG_SPEED_HIGH    = 3'd3,
    CFG_SCREEN_WIDTH  = 3'd4,
    CFG_SCREEN_HEIGHT = 3'd5
  } cfg_idx_e;

  // Event codes.
  localparam code_t CODE_REL_X   = 10'd0;
  localparam code_t CODE_REL_Y   = 10'd1;
  localparam code_t CODE_WHEEL   = 10'd8;
  localparam code_t CODE_BTN_L   = 10'd272;
  localparam code_t CODE_BTN_R   = 10'd273;
  localparam code_t CODE_BTN_M   = 10'd274;

  // Button mask bits.
  localparam logic [HELD_BITS-1:0] HELD_LEFT   = 3'b001;
  localparam logic [HELD_BITS-1:0] HELD_MIDDLE = 3'b010;
  localparam logic [HELD_BITS-1:0] HELD_RIGHT  = 3'b100;
  localparam logic [BTN_BITS-1:0]  BTN_WHEEL_UP   = 5'b01000;
  localparam logic [BTN_BITS-1:0]  BTN_WHEEL_DOWN = 5'b10000;

  typedef struct packed {
    logic [OP_BITS-1:0] operation;
    code_t              event_code;
    val_t               event_value;
  } in_item_t;

  typedef struct packed {
    coord_t              pointer_x;
    coord_t              pointer_y;
    logic [BTN_BITS-1:0] button_bits;
    logic                last_of_run;
  } out_item_t;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic [MUL_BITS-1:0] a;
    logic [MUL_BITS-1:0] b;
  } mul_op_t;

  // Half of a screen size, saturated to the largest coordinate.
  function automatic coord_t centre_coord(screen_t size);
    logic [CENTRE_BITS-1:0] half;
    half = CENTRE_BITS'(size >> 1);
    if (half > CENTRE_BITS'(COORD_MAX)) begin
      return COORD_MAX;
    end
    return half[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/mpa_mul.sv */
`default_nettype none

module mpa_mul import mpa_pkg::*; (
  input  logic                 clk_i,
  input  mul_op_t              op_i,
  output logic [PROD_BITS-1:0] prod_o
);

  logic [PROD_BITS-1:0] prod_q;

  // Unsigned product, registered before anyone uses it.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_BITS'(op_i.a) * PROD_BITS'(op_i.b);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* hdl/mouse_pointer_accelerator.sv */
`default_nettype none

// Mouse pointer accelerator.
// Input transactions carry relative mouse events (axis, button, end of batch).
// Output transactions carry the absolute pointer position and the button mask.
// A separate configuration channel writes the gain, speed threshold and screen
// size registers; it is always ready. The user must see that it is written only
// while the block is idle; the block itself does not enforce this. Button events
// and axis events other than the wheel leave the block idle, ready again on the
// next cycle. A wheel event gives two output transactions from the emit step,
// the first with the wheel bit set; the block is ready again after the second.
// An end of batch with motion steps through SQX, SQY, THH, THL, GAIN, SEL, SCX,
// SCY and POSY on one shared registered multiplier (two squares, two threshold
// squares, the gain product, two scaled deltas), then emits its result and
// takes the next input once idle again. A batch end without motion but with a
// button change goes straight to emit; a quiet batch end keeps the block idle.
// After reset both screen sizes are zero and every input transaction is
// accepted and dropped until both sizes are written; writing a size centres
// the pointer. When the receiver stalls, the last result waits in the output
// register while the block goes on; the block holds in its emit step only when
// a new result meets one that has not been taken.
module mouse_pointer_accelerator import mpa_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire in_item_t                 in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output out_item_t                     out_data_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_SQX  = 11'b00000000010,
    ST_SQY  = 11'b00000000100,
    ST_THH  = 11'b00000001000,
    ST_THL  = 11'b00000010000,
    ST_GAIN = 11'b00000100000,
    ST_SEL  = 11'b00001000000,
    ST_SCX  = 11'b00010000000,
    ST_SCY  = 11'b00100000000,
    ST_POSY = 11'b01000000000,
    ST_EMIT = 11'b10000000000
  } state_e;

  localparam logic [QSUM_BITS-1:0]  COORD_LIM = QSUM_BITS'(1) << COORD_BITS;
  localparam logic [GPROD_BITS-1:0] GAIN_ONE  = GPROD_BITS'(1) << FRAC_BITS;

  // Saturating add of an event delta into an accumulator.
  function automatic acc_t sat_add(acc_t acc, val_t v);
    logic signed [ACC_BITS:0] s;
    s = {acc[ACC_BITS-1], acc} + {{(ACC_BITS + 1 - VAL_BITS){v[VAL_BITS-1]}}, v};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? {1'b1, {(ACC_BITS - 1){1'b0}}} : {1'b0, {(ACC_BITS - 1){1'b1}}};
    end
    return s[ACC_BITS-1:0];
  endfunction

  // Mask bit of a button code, zero for codes that are not buttons.
  function automatic logic [HELD_BITS-1:0] button_bit(code_t code);
    logic [HELD_BITS-1:0] bit_mask;
    bit_mask = '0;
    if (code == CODE_BTN_L) begin
      bit_mask = HELD_LEFT;
    end else if (code == CODE_BTN_M) begin
      bit_mask = HELD_MIDDLE;
    end else if (code == CODE_BTN_R) begin
      bit_mask = HELD_RIGHT;
    end
    return bit_mask;
  endfunction

  // Moves a coordinate by a scaled delta and clamps it to the screen.
  function automatic coord_t move_coord(coord_t pos, logic [QBITS-1:0] q, logic neg,
                                        screen_t size);
    logic [QSUM_BITS-1:0] lim;
    logic [QSUM_BITS-1:0] sum;
    logic [QBITS-1:0]     diff;
    lim  = (QSUM_BITS'(size) >= COORD_LIM) ? COORD_LIM : QSUM_BITS'(size);
    sum  = QSUM_BITS'(pos) + QSUM_BITS'(q);
    diff = QBITS'(pos) - q;
    if (neg) begin
      if (q > QBITS'(pos)) begin
        return '0;
      end
      return diff[COORD_BITS-1:0];
    end
    if (sum >= lim) begin
      sum = lim - QSUM_BITS'(1);
    end
    return sum[COORD_BITS-1:0];
  endfunction

  state_e                  state_q, state_d;
  logic [GAIN_BITS-1:0]    gain_n_q, gain_n_d;
  logic [GAIN_BITS-1:0]    gain_b_q, gain_b_d;
  logic [SPD_LO_BITS-1:0]  spd_lo_q, spd_lo_d;
  logic [SPD_HI_BITS-1:0]  spd_hi_q, spd_hi_d;
  screen_t                 width_q, width_d;
  screen_t                 height_q, height_d;
  coord_t                  pos_x_q, pos_x_d;
  coord_t                  pos_y_q, pos_y_d;
  logic [HELD_BITS-1:0]    held_q, held_d;
  acc_t                    sum_dx_q, sum_dx_d;
  acc_t                    sum_dy_q, sum_dy_d;
  logic                    btn_moved_q, btn_moved_d;
  logic                    wheel_q, wheel_d;
  logic [BTN_BITS-1:0]     wheel_bits_q, wheel_bits_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_data_q, out_data_d;

  logic [SQ_BITS-1:0]      sq_q;
  logic [GPROD_BITS-1:0]   gain_q;
  logic                    ge_hi_q;
  logic                    ge_lo_q;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    enabled;
  logic                    slot_free;
  logic                    moved;
  logic [ACC_BITS-1:0]     mag_x;
  logic [ACC_BITS-1:0]     mag_y;
  mul_op_t                 mul_op;
  logic [PROD_BITS-1:0]    prod;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign enabled     = (width_q != '0) && (height_q != '0);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign moved       = (sum_dx_q != '0) || (sum_dy_q != '0);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Magnitudes of the accumulated motion.
  assign mag_x = sum_dx_q[ACC_BITS-1] ? ACC_BITS'(-sum_dx_q) : ACC_BITS'(sum_dx_q);
  assign mag_y = sum_dy_q[ACC_BITS-1] ? ACC_BITS'(-sum_dy_q) : ACC_BITS'(sum_dy_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    unique case (state_q)
      ST_SQX: begin
        mul_op.a = MUL_BITS'(mag_x);
        mul_op.b = MUL_BITS'(mag_x);
      end
      ST_SQY: begin
        mul_op.a = MUL_BITS'(mag_y);
        mul_op.b = MUL_BITS'(mag_y);
      end
      ST_THH: begin
        mul_op.a = MUL_BITS'(spd_hi_q);
        mul_op.b = MUL_BITS'(spd_hi_q);
      end
      ST_THL: begin
        mul_op.a = MUL_BITS'(spd_lo_q);
        mul_op.b = MUL_BITS'(spd_lo_q);
      end
      ST_GAIN: begin
        mul_op.a = MUL_BITS'(gain_n_q);
        mul_op.b = MUL_BITS'(gain_b_q);
      end
      ST_SCX: begin
        mul_op.a = MUL_BITS'(mag_x);
        mul_op.b = MUL_BITS'(gain_q);
      end
      ST_SCY: begin
        mul_op.a = MUL_BITS'(mag_y);
        mul_op.b = MUL_BITS'(gain_q);
      end
      default: begin
      end
    endcase
  end

  mpa_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  // Sequencer, event handling and configuration writes.
  always_comb begin
    state_d      = state_q;
    gain_n_d     = gain_n_q;
    gain_b_d     = gain_b_q;
    spd_lo_d     = spd_lo_q;
    spd_hi_d     = spd_hi_q;
    width_d      = width_q;
    height_d     = height_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    held_d       = held_q;
    sum_dx_d     = sum_dx_q;
    sum_dy_d     = sum_dy_q;
    btn_moved_d  = btn_moved_q;
    wheel_d      = wheel_q;
    wheel_bits_d = wheel_bits_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && enabled) begin
          if (in_data_i.operation == OP_AXIS) begin
            if (in_data_i.event_code == CODE_REL_X) begin
              sum_dx_d = sat_add(sum_dx_q, in_data_i.event_value);
            end else if (in_data_i.event_code == CODE_REL_Y) begin
              sum_dy_d = sat_add(sum_dy_q, in_data_i.event_value);
            end else if (in_data_i.event_code == CODE_WHEEL) begin
              wheel_d      = 1'b1;
              wheel_bits_d = (in_data_i.event_value > 0) ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
              state_d      = ST_EMIT;
            end
          end else if (in_data_i.operation == OP_BUTTON) begin
            if (in_data_i.event_value != '0) begin
              held_d = held_q | button_bit(in_data_i.event_code);
            end else begin
              held_d = held_q & ~button_bit(in_data_i.event_code);
            end
            if (held_d != held_q) begin
              btn_moved_d = 1'b1;
            end
          end else if (in_data_i.operation == OP_BATCH) begin
            if (moved) begin
              state_d = ST_SQX;
            end else begin
              sum_dx_d    = '0;
              sum_dy_d    = '0;
              btn_moved_d = 1'b0;
              if (btn_moved_q) begin
                state_d = ST_EMIT;
              end
            end
          end
        end
      end
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_THH;
      ST_THH:  state_d = ST_THL;
      ST_THL:  state_d = ST_GAIN;
      ST_GAIN: state_d = ST_SEL;
      ST_SEL:  state_d = ST_SCX;
      ST_SCX:  state_d = ST_SCY;
      ST_SCY: begin
        pos_x_d = move_coord(pos_x_q, prod[PROD_BITS-1:FRAC_BITS], sum_dx_q[ACC_BITS-1],
                             width_q);
        state_d = ST_POSY;
      end
      ST_POSY: begin
        pos_y_d     = move_coord(pos_y_q, prod[PROD_BITS-1:FRAC_BITS], sum_dy_q[ACC_BITS-1],
                                 height_q);
        sum_dx_d    = '0;
        sum_dy_d    = '0;
        btn_moved_d = 1'b0;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_data_d.pointer_x  = pos_x_q;
          out_data_d.pointer_y  = pos_y_q;
          if (wheel_q) begin
            // Wheel press half of the pair.
            out_data_d.button_bits = BTN_BITS'(held_q) | wheel_bits_q;
            out_data_d.last_of_run = 1'b0;
            wheel_d                = 1'b0;
          end else begin
            out_data_d.button_bits = BTN_BITS'(held_q);
            out_data_d.last_of_run = 1'b1;
            state_d                = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Configuration writes; a size write centres the pointer.
    if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_GAIN_NORMAL:   gain_n_d = cfg_data_i[GAIN_BITS-1:0];
        CFG_GAIN_BOOST:    gain_b_d = cfg_data_i[GAIN_BITS-1:0];
        CFG_SPEED_LOW:     spd_lo_d = cfg_data_i[SPD_LO_BITS-1:0];
        CFG_SPEED_HIGH:    spd_hi_d = cfg_data_i[SPD_HI_BITS-1:0];
        CFG_SCREEN_WIDTH: begin
          width_d = cfg_data_i[SCREEN_BITS-1:0];
          pos_x_d = centre_coord(width_d);
          pos_y_d = centre_coord(height_d);
        end
        CFG_SCREEN_HEIGHT: begin
          height_d = cfg_data_i[SCREEN_BITS-1:0];
          pos_x_d  = centre_coord(width_d);
          pos_y_d  = centre_coord(height_d);
        end
        default: begin
        end
      endcase
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gain_n_q     <= GAIN_BITS'(256);
      gain_b_q     <= GAIN_BITS'(512);
      spd_lo_q     <= SPD_LO_BITS'(4);
      spd_hi_q     <= SPD_HI_BITS'(20);
      width_q      <= '0;
      height_q     <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      held_q       <= '0;
      sum_dx_q     <= '0;
      sum_dy_q     <= '0;
      btn_moved_q  <= 1'b0;
      wheel_q      <= 1'b0;
      wheel_bits_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      gain_n_q     <= gain_n_d;
      gain_b_q     <= gain_b_d;
      spd_lo_q     <= spd_lo_d;
      spd_hi_q     <= spd_hi_d;
      width_q      <= width_d;
      height_q     <= height_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      held_q       <= held_d;
      sum_dx_q     <= sum_dx_d;
      sum_dy_q     <= sum_dy_d;
      btn_moved_q  <= btn_moved_d;
      wheel_q      <= wheel_d;
      wheel_bits_q <= wheel_bits_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // Squared speed, threshold compares and gain selection.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_SQY:  sq_q    <= prod[SQ_BITS-1:0];
      ST_THH:  sq_q    <= sq_q + prod[SQ_BITS-1:0];
      ST_THL:  ge_hi_q <= (PROD_BITS'(sq_q) >= prod);
      ST_GAIN: ge_lo_q <= (PROD_BITS'(sq_q) >= prod);
      ST_SEL: begin
        if (ge_hi_q) begin
          gain_q <= prod[GPROD_BITS-1:0];
        end else if (ge_lo_q) begin
          gain_q <= GPROD_BITS'({gain_n_q, 8'b0});
        end else begin
          gain_q <= GAIN_ONE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpa_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam longint ACC_HI = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint UNITY_GAIN = longint'(1) <<< FRAC_BITS;
  localparam longint COORD_SPAN = longint'(1) <<< COORD_BITS;

  // Codes the block must ignore.
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam code_t CODE_AXIS_UNKNOWN = 10'd2;
  localparam code_t CODE_BTN_UNKNOWN  = 10'd275;

  // Button masks used in the directed table.
  localparam logic [BTN_BITS-1:0] NO_BTN    = '0;
  localparam logic [BTN_BITS-1:0] ALL_HELD  = BTN_BITS'(HELD_LEFT | HELD_MIDDLE | HELD_RIGHT);
  localparam logic [BTN_BITS-1:0] MID_RIGHT = BTN_BITS'(HELD_MIDDLE | HELD_RIGHT);

  // Screen used by the directed part; the pointer starts at its center.
  localparam int DIR_W = 1000;
  localparam int DIR_H = 600;
  localparam int CX = DIR_W / 2;
  localparam int CY = DIR_H / 2;
  localparam int ENABLE_ROW = 4;

  typedef struct {
    in_item_t  item;
    bit        typed;
    int        count;
    out_item_t first;
    out_item_t second;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_data = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_ready_o, out_valid_o, cfg_ready_o;
  out_item_t out_data_o;

  // Shadow of the block's registers and pointer state.
  logic [GAIN_BITS-1:0]   gain_n, gain_b;
  logic [SPD_LO_BITS-1:0] spd_lo;
  logic [SPD_HI_BITS-1:0] spd_hi;
  screen_t                scr_w, scr_h;
  coord_t                 ptr_x, ptr_y;
  logic [HELD_BITS-1:0]   held;
  logic                   btn_changed;
  acc_t                   sum_x, sum_y;

  out_item_t pending_reports[$];
  script_row_t script[$];

  int mismatches = 0;
  int reports_seen = 0;
  int events_sent = 0;
  int live_events = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int send_gap_pct = 10;
  int out_stall_pct = 10;
  bit calm = 1'b0;

  mouse_pointer_accelerator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic in_item_t mk_event(logic [OP_BITS-1:0] op, code_t code, int value);
    in_item_t it;
    it.operation = op;
    it.event_code = code;
    it.event_value = val_t'(value);
    return it;
  endfunction

  function automatic out_item_t mk_report(int x, int y, logic [BTN_BITS-1:0] btn, logic last);
    out_item_t r;
    r.pointer_x = coord_t'(x);
    r.pointer_y = coord_t'(y);
    r.button_bits = btn;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic acc_t sat_acc(acc_t s, longint v);
    longint t;
    t = longint'(s) + v;
    if (t > ACC_HI) begin
      t = ACC_HI;
    end else if (t < ACC_LO) begin
      t = ACC_LO;
    end
    return acc_t'(t);
  endfunction

  // Delta times the Q10.16 gain, truncated toward zero.
  function automatic longint scale_delta(acc_t d, longint g);
    longint mag, q;
    mag = (d < 0) ? -longint'(d) : longint'(d);
    q = (mag * g) >>> FRAC_BITS;
    return (d < 0) ? -q : q;
  endfunction

  function automatic coord_t clamp_coord(longint p, screen_t size);
    longint lim;
    lim = (longint'(size) < COORD_SPAN) ? longint'(size) : COORD_SPAN;
    if (p < 0) begin
      return '0;
    end
    if (p >= lim) begin
      return coord_t'(lim - 1);
    end
    return coord_t'(p);
  endfunction

  function automatic coord_t half_size(screen_t size);
    screen_t h;
    h = size >> 1;
    return (h > screen_t'(COORD_MAX)) ? COORD_MAX : h[COORD_BITS-1:0];
  endfunction

  // Register write as seen by the shadow state; a size write recenters.
  function automatic void apply_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      CFG_GAIN_NORMAL: gain_n = d[GAIN_BITS-1:0];
      CFG_GAIN_BOOST: gain_b = d[GAIN_BITS-1:0];
      CFG_SPEED_LOW: spd_lo = d[SPD_LO_BITS-1:0];
      CFG_SPEED_HIGH: spd_hi = d[SPD_HI_BITS-1:0];
      CFG_SCREEN_WIDTH: scr_w = d[SCREEN_BITS-1:0];
      CFG_SCREEN_HEIGHT: scr_h = d[SCREEN_BITS-1:0];
      default: ;
    endcase
    if (idx == CFG_SCREEN_WIDTH || idx == CFG_SCREEN_HEIGHT) begin
      ptr_x = half_size(scr_w);
      ptr_y = half_size(scr_h);
    end
  endfunction

  // Predicts the reports one accepted event causes and advances the state.
  function automatic int predict_reports(in_item_t it, output out_item_t r0,
                                         output out_item_t r1);
    longint v, ax, ay, sq, g;
    logic [HELD_BITS-1:0] sel, old;
    r0 = '0;
    r1 = '0;
    v = longint'($signed(it.event_value));
    if (scr_w == 0 || scr_h == 0) begin
      return 0;
    end
    case (it.operation)
      OP_AXIS: begin
        if (it.event_code == CODE_REL_X) begin
          sum_x = sat_acc(sum_x, v);
        end else if (it.event_code == CODE_REL_Y) begin
          sum_y = sat_acc(sum_y, v);
        end else if (it.event_code == CODE_WHEEL) begin
          r0 = mk_report(ptr_x, ptr_y,
                         BTN_BITS'(held) | ((v > 0) ? BTN_WHEEL_UP : BTN_WHEEL_DOWN), 1'b0);
          r1 = mk_report(ptr_x, ptr_y, BTN_BITS'(held), 1'b1);
          return 2;
        end
        return 0;
      end
      OP_BUTTON: begin
        case (it.event_code)
          CODE_BTN_L: sel = HELD_LEFT;
          CODE_BTN_M: sel = HELD_MIDDLE;
          CODE_BTN_R: sel = HELD_RIGHT;
          default: sel = '0;
        endcase
        old = held;
        held = (v != 0) ? (held | sel) : (held & ~sel);
        if (held != old) begin
          btn_changed = 1'b1;
        end
        return 0;
      end
      OP_BATCH: begin
        if (sum_x != 0 || sum_y != 0) begin
          ax = (sum_x < 0) ? -longint'(sum_x) : longint'(sum_x);
          ay = (sum_y < 0) ? -longint'(sum_y) : longint'(sum_y);
          sq = ax * ax + ay * ay;
          // Speed thresholds are compared squared; the high one wins.
          if (sq >= longint'(spd_hi) * longint'(spd_hi)) begin
            g = longint'(gain_n) * longint'(gain_b);
          end else if (sq >= longint'(spd_lo) * longint'(spd_lo)) begin
            g = longint'(gain_n) <<< 8;
          end else begin
            g = UNITY_GAIN;
          end
          ptr_x = clamp_coord(longint'(ptr_x) + scale_delta(sum_x, g), scr_w);
          ptr_y = clamp_coord(longint'(ptr_y) + scale_delta(sum_y, g), scr_h);
          btn_changed = 1'b1;
        end
        r0 = mk_report(ptr_x, ptr_y, BTN_BITS'(held), 1'b1);
        sum_x = '0;
        sum_y = '0;
        if (btn_changed) begin
          btn_changed = 1'b0;
          return 1;
        end
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  task automatic post_expected(int n, out_item_t r0, out_item_t r1);
    if (n > 0) begin
      pending_reports.push_back(r0);
    end
    if (n > 1) begin
      pending_reports.push_back(r1);
    end
  endtask

  // Drives one input transaction and returns at the edge that accepts it.
  task automatic push_event(in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready_o);
    events_sent++;
    if (scr_w != 0 && scr_h != 0) begin
      live_events++;
    end
  endtask

  task automatic send_event(in_item_t it);
    out_item_t r0, r1;
    int n;
    push_event(it);
    n = predict_reports(it, r0, r1);
    post_expected(n, r0, r1);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, CFG_DATA_BITS'(value));
    reg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending, waits for every pending report, then lets a quiet
  // batch end finish before anything else happens.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic val_t rand_delta();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return val_t'(int'($urandom_range(0, 40)) - 20);
    end
    if (pick < 8) begin
      return val_t'(int'($urandom_range(0, 1000)) - 500);
    end
    return val_t'($urandom());
  endfunction

  // Random event inside a batch: mostly motion, some buttons, wheels and noise.
  function automatic in_item_t rand_motion();
    int pick;
    code_t btn;
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      return mk_event(OP_AXIS, CODE_REL_X, rand_delta());
    end
    if (pick < 72) begin
      return mk_event(OP_AXIS, CODE_REL_Y, rand_delta());
    end
    if (pick < 86) begin
      case ($urandom_range(0, 2))
        0: btn = CODE_BTN_L;
        1: btn = CODE_BTN_M;
        default: btn = CODE_BTN_R;
      endcase
      return mk_event(OP_BUTTON, btn, $urandom_range(0, 1) ? 0 : int'($urandom()));
    end
    if (pick < 93) begin
      return mk_event(OP_AXIS, CODE_WHEEL,
                      $urandom_range(0, 2) == 0 ? int'($urandom())
                                                : int'($urandom_range(0, 2)) - 1);
    end
    return mk_event($urandom_range(0, 3), code_t'($urandom()), int'($urandom()));
  endfunction

  // Programs all registers, then sends random batches until the quota is used.
  task automatic run_phase(int gn, int gb, int lo, int hi, int w, int h, int quota);
    int sent, len, k;
    settle();
    write_reg(CFG_GAIN_NORMAL, gn);
    write_reg(CFG_GAIN_BOOST, gb);
    write_reg(CFG_SPEED_LOW, lo);
    write_reg(CFG_SPEED_HIGH, hi);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    send_gap_pct = 8 * $urandom_range(0, 3);
    out_stall_pct = 8 * $urandom_range(0, 3);
    sent = 0;
    while (sent < quota) begin
      len = $urandom_range(0, 8);
      for (k = 0; k < len && sent < quota; k++) begin
        send_event(rand_motion());
        sent++;
      end
      if (sent < quota) begin
        send_event(mk_event(OP_BATCH, code_t'($urandom()), int'($urandom())));
        sent++;
      end
    end
  endtask

  // Receiver stalls come in bursts.
  always @(negedge clk_i) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left = $urandom_range(1, 17);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Each output transaction is compared with the oldest pending report.
  always @(posedge clk_i) begin : report_check
    out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got x=%0d y=%0d buttons=%0d last=%0d",
                 $time, out_data_o.pointer_x, out_data_o.pointer_y,
                 out_data_o.button_bits, out_data_o.last_of_run);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("pointer_x", want.pointer_x, out_data_o.pointer_x);
        check_field("pointer_y", want.pointer_y, out_data_o.pointer_y);
        check_field("button_bits", want.button_bits, out_data_o.button_bits);
        check_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d reports still pending",
               $time, quiet_cycles, pending_reports.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_item_t r0, r1;
    int n, k;

    // Shadow state after reset: both sizes zero, so the block is disabled.
    gain_n = 13'd256;
    gain_b = 13'd512;
    spd_lo = 7'd4;
    spd_hi = 9'd20;
    scr_w = '0;
    scr_h = '0;
    ptr_x = '0;
    ptr_y = '0;
    held = '0;
    btn_changed = 1'b0;
    sum_x = '0;
    sum_y = '0;

    // The first rows arrive while disabled and must leave no trace.
    script = '{
      '{mk_event(OP_AXIS, CODE_REL_X, 100), 1'b1, 0, '0, '0},
      '{mk_event(OP_AXIS, CODE_WHEEL, 1), 1'b1, 0, '0, '0},
      '{mk_event(OP_BUTTON, CODE_BTN_L, 1), 1'b1, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_REL_X, 0), 1'b1, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_REL_X, 0), 1'b1, 0, '0, '0},
      '{mk_event(OP_AXIS, CODE_WHEEL, 1), 1'b1, 2,
        mk_report(CX, CY, BTN_WHEEL_UP, 1'b0), mk_report(CX, CY, NO_BTN, 1'b1)},
      '{mk_event(OP_AXIS, CODE_WHEEL, 0), 1'b1, 2,
        mk_report(CX, CY, BTN_WHEEL_DOWN, 1'b0), mk_report(CX, CY, NO_BTN, 1'b1)},
      '{mk_event(OP_AXIS, CODE_WHEEL, -32768), 1'b1, 2,
        mk_report(CX, CY, BTN_WHEEL_DOWN, 1'b0), mk_report(CX, CY, NO_BTN, 1'b1)},
      '{mk_event(OP_BUTTON, CODE_BTN_L, 1), 1'b1, 0, '0, '0},
      '{mk_event(OP_BUTTON, CODE_BTN_R, -1), 1'b1, 0, '0, '0},
      '{mk_event(OP_BUTTON, CODE_BTN_M, 32767), 1'b1, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_REL_X, 0), 1'b1, 1, mk_report(CX, CY, ALL_HELD, 1'b1), '0},
      '{mk_event(OP_AXIS, CODE_WHEEL, 32767), 1'b1, 2,
        mk_report(CX, CY, ALL_HELD | BTN_WHEEL_UP, 1'b0), mk_report(CX, CY, ALL_HELD, 1'b1)},
      '{mk_event(OP_BUTTON, CODE_BTN_L, 0), 1'b1, 0, '0, '0},
      '{mk_event(OP_BUTTON, CODE_BTN_UNKNOWN, 1), 1'b1, 0, '0, '0},
      '{mk_event(OP_UNUSED, CODE_REL_X, 5), 1'b1, 0, '0, '0},
      '{mk_event(OP_AXIS, CODE_AXIS_UNKNOWN, 100), 1'b1, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_REL_X, 0), 1'b1, 1, mk_report(CX, CY, MID_RIGHT, 1'b1), '0},
      '{mk_event(OP_BATCH, CODE_REL_X, 0), 1'b1, 0, '0, '0},
      '{mk_event(OP_AXIS, CODE_REL_X, 3), 1'b0, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_REL_X, 0), 1'b1, 1, mk_report(CX + 3, CY, MID_RIGHT, 1'b1), '0},
      '{mk_event(OP_AXIS, CODE_REL_X, -32768), 1'b0, 0, '0, '0},
      '{mk_event(OP_AXIS, CODE_REL_Y, 32767), 1'b0, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_REL_X, 0), 1'b1, 1, mk_report(0, DIR_H - 1, MID_RIGHT, 1'b1), '0},
      '{mk_event(OP_AXIS, CODE_REL_X, 10), 1'b0, 0, '0, '0},
      '{mk_event(OP_AXIS, CODE_REL_Y, -10), 1'b0, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_REL_Y, -1), 1'b0, 0, '0, '0},
      '{mk_event(OP_BUTTON, CODE_BTN_R, 0), 1'b0, 0, '0, '0},
      '{mk_event(OP_BATCH, CODE_BTN_R, 7), 1'b0, 0, '0, '0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed part: typed rows override the prediction, the rest use it.
    foreach (script[i]) begin
      if (i == ENABLE_ROW) begin
        settle();
        write_reg(CFG_SCREEN_WIDTH, DIR_W);
        write_reg(CFG_SCREEN_HEIGHT, DIR_H);
      end
      push_event(script[i].item);
      n = predict_reports(script[i].item, r0, r1);
      if (script[i].typed) begin
        n = script[i].count;
        r0 = script[i].first;
        r1 = script[i].second;
      end
      post_expected(n, r0, r1);
    end

    // Drive both accumulators past their limits, then step back from one.
    for (k = 0; k < 265; k++) begin
      send_event(mk_event(OP_AXIS, CODE_REL_X, 32767));
      send_event(mk_event(OP_AXIS, CODE_REL_Y, -32768));
    end
    send_event(mk_event(OP_AXIS, CODE_REL_X, -5));
    send_event(mk_event(OP_BATCH, CODE_REL_X, 0));

    // Register extremes, a disabled setting, then random settings.
    run_phase(26, 26, 0, 1, 8192, 8192, 180);
    run_phase(5120, 5120, 99, 499, 1, 1, 120);
    run_phase(8191, 8191, 127, 511, 16383, 16383, 150);
    run_phase(0, 300, 10, 0, 640, 480, 120);
    run_phase(256, 512, 4, 20, 800, 0, 40);
    for (k = 0; k < 3; k++) begin
      run_phase($urandom_range(26, 5120), $urandom_range(26, 5120), $urandom_range(0, 99),
                $urandom_range(1, 499), $urandom_range(1, 8192), $urandom_range(1, 8192), 150);
    end

    // Closing stretch with neither side idling.
    calm = 1'b1;
    run_phase($urandom_range(26, 5120), $urandom_range(26, 5120), $urandom_range(0, 99),
              $urandom_range(1, 499), $urandom_range(1, 8192), $urandom_range(1, 8192), 150);
    settle();

    $display("Sent %0d input events (%0d with the pointer enabled) across %0d register writes.",
             events_sent, live_events, reg_writes);
    $display("Checked %0d output reports, %0d mismatches.", reports_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
